/* hdl/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared widths, codes and controller/datapath handshake types for the
// text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // default screen geometry
  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  // field widths
  localparam int KIND_W     = 3;
  localparam int CHAR_W     = 8;
  localparam int ARG_W      = 8;
  localparam int COL_W      = 7;
  localparam int ROW_W      = 5;
  localparam int OFFSET_W   = 11;
  localparam int CELL_W     = 16;
  localparam int COLOUR_W   = 4;
  localparam int CFG_ADDR_W = 2;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_WRITE = 3'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SET   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_MOVE  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ  = 3'd4;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_FG = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_BG = 2'd1;

  // register reset values
  localparam logic [COLOUR_W-1:0] FG_RESET = 4'd2;
  localparam logic [COLOUR_W-1:0] BG_RESET = 4'd0;

  // character codes
  localparam logic [CHAR_W-1:0] CODE_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CODE_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CODE_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CODE_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CODE_FIRST = 8'h20;
  localparam logic [CHAR_W-1:0] CODE_LAST  = 8'h7F;

  // cell value written by clear
  localparam logic [CELL_W-1:0] CLEAR_CELL = 16'h0200;

  // controller to datapath commands
  typedef struct packed {
    logic accept;
    logic exec;
    logic rd_capture;
    logic prime;
    logic scroll_step;
    logic fill_step;
    logic fill_blank;
    logic out_load;
  } tcw_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              need_scroll;
    logic              read_hit;
    logic              sweep_last;
    logic              out_free;
  } tcw_status_t;

endpackage

/* hdl/tcw_ram.sv */
// ----------------------------------------------------------------------------
// tcw_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* hdl/tcw_ctrl.sv */
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer for the text console writer: reset fill, request execution,
// scroll and clear sweeps, and result hand-off.
// ----------------------------------------------------------------------------
module tcw_ctrl import tcw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  tcw_status_t status_i,
  output tcw_cmd_t    cmd_o
);

  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_EXEC   = 3'd2;
  localparam logic [2:0] ST_RDWAIT = 3'd3;
  localparam logic [2:0] ST_PRIME  = 3'd4;
  localparam logic [2:0] ST_SCROLL = 3'd5;
  localparam logic [2:0] ST_CLEAR  = 3'd6;
  localparam logic [2:0] ST_RESULT = 3'd7;

  logic [2:0] state_d, state_q;

  assign in_stall_o = (state_q != ST_IDLE);

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_INIT: begin
        cmd_o.fill_step  = 1'b1;
        cmd_o.fill_blank = 1'b1;
        if (status_i.sweep_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        case (status_i.kind)
          KIND_WRITE: state_d = status_i.need_scroll ? ST_PRIME : ST_RESULT;
          KIND_CLEAR: state_d = ST_CLEAR;
          KIND_READ:  state_d = status_i.read_hit ? ST_RDWAIT : ST_RESULT;
          default:    state_d = ST_RESULT;
        endcase
      end
      ST_RDWAIT: begin
        cmd_o.rd_capture = 1'b1;
        state_d          = ST_RESULT;
      end
      ST_PRIME: begin
        cmd_o.prime = 1'b1;
        state_d     = ST_SCROLL;
      end
      ST_SCROLL: begin
        cmd_o.scroll_step = 1'b1;
        if (status_i.sweep_last) state_d = ST_RESULT;
      end
      ST_CLEAR: begin
        cmd_o.fill_step = 1'b1;
        if (status_i.sweep_last) state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* hdl/tcw_datapath.sv */
// ----------------------------------------------------------------------------
// tcw_datapath
// Cursor, colour registers, screen store with sweep pointer, and the
// result register of the text console writer.
// ----------------------------------------------------------------------------
module tcw_datapath import tcw_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tcw_cmd_t              cmd_i,
  output tcw_status_t           status_o,
  input  logic [KIND_W-1:0]     kind_i,
  input  logic [CHAR_W-1:0]     char_code_i,
  input  logic [ARG_W-1:0]      col_arg_i,
  input  logic [ARG_W-1:0]      row_arg_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_index_i,
  input  logic [COLOUR_W-1:0]   cfg_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [COL_W-1:0]      cursor_x_o,
  output logic [ROW_W-1:0]      cursor_y_o,
  output logic [OFFSET_W-1:0]   cursor_offset_o,
  output logic [CELL_W-1:0]     read_data_o,
  output logic                  scrolled_o
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int OFF_FULL_W = ROW_W + COL_W;

  localparam logic [AW-1:0]    COLS_A     = AW'(COLUMNS);
  localparam logic [AW-1:0]    CELL_LAST  = AW'(CELLS - 1);
  localparam logic [AW-1:0]    SHIFT_END  = AW'(CELLS - COLUMNS);
  localparam logic [AW:0]      SRC_STEP   = (AW+1)'(COLUMNS + 1);
  localparam logic [AW:0]      CELLS_X    = (AW+1)'(CELLS);
  localparam logic [COL_W:0]   COL_END    = (COL_W+1)'(COLUMNS);
  localparam logic [COL_W-1:0] COL_LAST   = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W:0]   ROW_END    = (ROW_W+1)'(ROWS);
  localparam logic [ROW_W-1:0] ROW_LAST   = ROW_W'(ROWS - 1);
  localparam logic [ARG_W:0]   SUM_COL_LIM = (ARG_W+1)'(COLUMNS - 1);
  localparam logic [ARG_W:0]   SUM_ROW_LIM = (ARG_W+1)'(ROWS - 1);
  localparam logic [ARG_W:0]   ARG_COL_END = (ARG_W+1)'(COLUMNS);
  localparam logic [ARG_W:0]   ARG_ROW_END = (ARG_W+1)'(ROWS);

  // request registers
  logic [KIND_W-1:0] kind_q;
  logic [CHAR_W-1:0] code_q;
  logic [ARG_W-1:0]  carg_q, rarg_q;

  // cursor, colours and sweep pointer
  logic [COL_W-1:0]    col_q;
  logic [ROW_W-1:0]    row_q;
  logic [COLOUR_W-1:0] fg_q, bg_q;
  logic [AW-1:0]       ptr_q;

  // per-request result registers
  logic [CELL_W-1:0] rdata_q;
  logic              scrolled_q;
  logic              out_valid_q;

  // memory port signals
  logic              mem_we;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [CELL_W-1:0] mem_wdata, mem_rdata;

  function automatic logic [AW-1:0] cell_addr(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
    return AW'(r) * COLS_A + AW'(c);
  endfunction

  // character write: next cursor, store enable and scroll need
  logic [COL_W-1:0]  wc_col;
  logic [ROW_W:0]    wc_row_ext;
  logic [ROW_W-1:0]  wc_row;
  logic [COL_W:0]    col_inc;
  logic              wc_we;
  logic [CHAR_W-1:0] wc_char;
  logic [COL_W-1:0]  wc_addr_col;
  logic              need_scroll;

  always_comb begin
    col_inc     = {1'b0, col_q} + (COL_W+1)'(1);
    wc_col      = col_q;
    wc_row_ext  = {1'b0, row_q};
    wc_we       = 1'b0;
    wc_char     = code_q;
    wc_addr_col = col_q;
    if (code_q == CODE_BS) begin
      if (col_q != '0) begin
        wc_col      = col_q - COL_W'(1);
        wc_addr_col = col_q - COL_W'(1);
        wc_we       = 1'b1;
        wc_char     = CODE_SPACE;
      end
    end else if (code_q == CODE_CR) begin
      wc_col = '0;
    end else if (code_q == CODE_LF) begin
      wc_col     = '0;
      wc_row_ext = {1'b0, row_q} + (ROW_W+1)'(1);
    end else if (code_q inside {[CODE_FIRST:CODE_LAST]}) begin
      wc_we = 1'b1;
      if (col_inc == COL_END) begin
        wc_col     = '0;
        wc_row_ext = {1'b0, row_q} + (ROW_W+1)'(1);
      end else begin
        wc_col = col_inc[COL_W-1:0];
      end
    end
    need_scroll = (wc_row_ext >= ROW_END);
    wc_row      = need_scroll ? ROW_LAST : wc_row_ext[ROW_W-1:0];
  end

  // set and move saturation, read bounds
  logic [ARG_W:0]   mv_col_sum, mv_row_sum;
  logic [COL_W-1:0] set_col, mv_col;
  logic [ROW_W-1:0] set_row, mv_row;
  logic             read_hit;
  logic [AW-1:0]    read_addr;

  always_comb begin
    mv_col_sum = (ARG_W+1)'(col_q) + {1'b0, carg_q};
    mv_row_sum = (ARG_W+1)'(row_q) + {1'b0, rarg_q};
    set_col    = ({1'b0, carg_q} > SUM_COL_LIM) ? COL_LAST : carg_q[COL_W-1:0];
    set_row    = ({1'b0, rarg_q} > SUM_ROW_LIM) ? ROW_LAST : rarg_q[ROW_W-1:0];
    mv_col     = (mv_col_sum > SUM_COL_LIM) ? COL_LAST : mv_col_sum[COL_W-1:0];
    mv_row     = (mv_row_sum > SUM_ROW_LIM) ? ROW_LAST : mv_row_sum[ROW_W-1:0];
    read_hit   = ({1'b0, carg_q} < ARG_COL_END) && ({1'b0, rarg_q} < ARG_ROW_END);
    read_addr  = cell_addr(rarg_q[ROW_W-1:0], carg_q[COL_W-1:0]);
  end

  // memory port selection
  logic [AW:0] src_next;

  always_comb begin
    src_next  = {1'b0, ptr_q} + SRC_STEP;
    mem_we    = 1'b0;
    mem_waddr = ptr_q;
    mem_wdata = '0;
    mem_raddr = '0;
    if (cmd_i.exec && (kind_q == KIND_WRITE) && wc_we) begin
      mem_we    = 1'b1;
      mem_waddr = cell_addr(row_q, wc_addr_col);
      mem_wdata = {bg_q, fg_q, wc_char};
    end
    if (cmd_i.exec && (kind_q == KIND_READ)) begin
      mem_raddr = read_addr;
    end
    if (cmd_i.prime) begin
      mem_raddr = COLS_A;
    end
    if (cmd_i.scroll_step) begin
      mem_we    = 1'b1;
      mem_wdata = (ptr_q < SHIFT_END) ? mem_rdata : '0;
      mem_raddr = (src_next < CELLS_X) ? src_next[AW-1:0] : '0;
    end
    if (cmd_i.fill_step) begin
      mem_we    = 1'b1;
      mem_wdata = cmd_i.fill_blank ? '0 : CLEAR_CELL;
    end
  end

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q <= kind_i;
      code_q <= char_code_i;
      carg_q <= col_arg_i;
      rarg_q <= row_arg_i;
    end
  end

  // cursor, colours, sweep pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      fg_q  <= FG_RESET;
      bg_q  <= BG_RESET;
      ptr_q <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_IDX_FG) fg_q <= cfg_data_i;
        if (cfg_index_i == CFG_IDX_BG) bg_q <= cfg_data_i;
      end
      if (cmd_i.exec) begin
        case (kind_q)
          KIND_WRITE: begin
            col_q <= wc_col;
            row_q <= wc_row;
          end
          KIND_CLEAR: begin
            col_q <= '0;
            row_q <= '0;
          end
          KIND_SET: begin
            col_q <= set_col;
            row_q <= set_row;
          end
          KIND_MOVE: begin
            col_q <= mv_col;
            row_q <= mv_row;
          end
          default: ;
        endcase
      end
      if (cmd_i.fill_step || cmd_i.scroll_step) begin
        ptr_q <= (ptr_q == CELL_LAST) ? '0 : ptr_q + AW'(1);
      end
    end
  end

  // read data and scroll flag for the current request
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      rdata_q    <= '0;
      scrolled_q <= (kind_q == KIND_WRITE) && need_scroll;
    end else if (cmd_i.rd_capture) begin
      rdata_q <= mem_rdata;
    end
  end

  // result register
  logic [OFF_FULL_W-1:0] off_full;
  assign off_full = OFF_FULL_W'(row_q) * OFF_FULL_W'(COLUMNS) + OFF_FULL_W'(col_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      cursor_x_o      <= col_q;
      cursor_y_o      <= row_q;
      cursor_offset_o <= off_full[OFFSET_W-1:0];
      read_data_o     <= rdata_q;
      scrolled_o      <= scrolled_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // status to the controller
  assign status_o.kind        = kind_q;
  assign status_o.need_scroll = need_scroll;
  assign status_o.read_hit    = read_hit;
  assign status_o.sweep_last  = (ptr_q == CELL_LAST);
  assign status_o.out_free    = !out_valid_q || !out_stall_i;

endmodule

/* hdl/text_console_writer_top.sv */
// ----------------------------------------------------------------------------
// text_console_writer_top
// Character-cell text console with cursor, scrolling and clear.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the input channel (in_valid_i / in_stall_o) with kind,
//   char_code, col_arg and row_arg. Each request gives one result on the
//   output channel (out_valid_o / out_stall_i): cursor, linear offset,
//   read data and a scroll flag. Colours are set over the cfg channel,
//   which is always ready; write it only while no request is in flight.
//   Sequence: an accepted request passes through the execute state to the
//   result state, with a read-wait state between for an in-range cell read;
//   a scroll adds a prime state and a sweep over all COLUMNS*ROWS cells and
//   a clear adds a sweep alone, one cell per cycle through the single write
//   port of the screen RAM. The next request is taken once the previous one
//   has reached the result register, so requests never overlap.
//   Reset: after rst_ni is released the screen RAM is swept to zero over
//   all COLUMNS*ROWS cells, during which in_stall_o is high.
//   Output stall: a waiting result holds; the next request is still
//   accepted and runs, and then waits until the result register frees.
// ----------------------------------------------------------------------------
module text_console_writer_top import tcw_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [KIND_W-1:0]     kind_i,
  input  logic [CHAR_W-1:0]     char_code_i,
  input  logic [ARG_W-1:0]      col_arg_i,
  input  logic [ARG_W-1:0]      row_arg_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [COL_W-1:0]      cursor_x_o,
  output logic [ROW_W-1:0]      cursor_y_o,
  output logic [OFFSET_W-1:0]   cursor_offset_o,
  output logic [CELL_W-1:0]     read_data_o,
  output logic                  scrolled_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_ADDR_W-1:0] cfg_index_i,
  input  logic [COLOUR_W-1:0]   cfg_data_i
);

  tcw_cmd_t    cmd;
  tcw_status_t status;

  // configuration writes are taken in any cycle
  assign cfg_ready_o = 1'b1;

  tcw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .kind_i          (kind_i),
    .char_code_i     (char_code_i),
    .col_arg_i       (col_arg_i),
    .row_arg_i       (row_arg_i),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .cursor_x_o      (cursor_x_o),
    .cursor_y_o      (cursor_y_o),
    .cursor_offset_o (cursor_offset_o),
    .read_data_o     (read_data_o),
    .scrolled_o      (scrolled_o)
  );

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the text console writer. A driver presents console
// requests from a queue, a shadow screen and cursor predict each report, and a
// monitor compares every report field by field. Colours are reprogrammed
// between phases while the console is idle; both channels idle at random.
// ----------------------------------------------------------------------------
module tb;
  import tcw_pkg::*;

  localparam int COLUMNS         = DEF_COLUMNS;
  localparam int ROWS            = DEF_ROWS;
  localparam int CELLS           = COLUMNS * ROWS;
  localparam int RANDOM_PHASES   = 8;
  localparam int REQS_PER_PHASE  = 212;
  localparam int SETTLE_CYCLES   = 16;
  localparam int MAX_ERR_LINES   = 40;
  // worst case per request: full-screen sweep, longest gap, longest stall,
  // with a wide margin on top
  localparam int unsigned CYCLE_LIMIT = 20_000_000;

  localparam logic [KIND_W-1:0]     KIND_SPARE_LO = 3'd5;
  localparam logic [KIND_W-1:0]     KIND_SPARE_HI = 3'd7;
  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_SPARE = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CHAR_W-1:0] code;
    logic [ARG_W-1:0]  col;
    logic [ARG_W-1:0]  row;
  } console_req_t;

  typedef struct packed {
    logic [COL_W-1:0]    x;
    logic [ROW_W-1:0]    y;
    logic [OFFSET_W-1:0] offset;
    logic [CELL_W-1:0]   rdata;
    logic                scrolled;
  } cursor_report_t;

  // dut connections, all inputs known from time zero
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  logic [KIND_W-1:0]     kind_i      = '0;
  logic [CHAR_W-1:0]     char_code_i = '0;
  logic [ARG_W-1:0]      col_arg_i   = '0;
  logic [ARG_W-1:0]      row_arg_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [COL_W-1:0]      cursor_x_o;
  logic [ROW_W-1:0]      cursor_y_o;
  logic [OFFSET_W-1:0]   cursor_offset_o;
  logic [CELL_W-1:0]     read_data_o;
  logic                  scrolled_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_ADDR_W-1:0] cfg_index_i = '0;
  logic [COLOUR_W-1:0]   cfg_data_i  = '0;

  // shadow console state
  logic [CELL_W-1:0]   shadow_screen [CELLS];
  logic [COLOUR_W-1:0] model_fg = FG_RESET;
  logic [COLOUR_W-1:0] model_bg = BG_RESET;
  int                  cur_col  = 0;
  int                  cur_row  = 0;

  console_req_t   pending_reqs[$];
  cursor_report_t expected_reports[$];

  int unsigned cycle_cnt = 0;
  int          err_cnt   = 0;

  // driver and monitor scratch
  console_req_t   drv_cur;
  int             drv_gap;
  int             drv_calm;
  int             drv_roll;
  cursor_report_t mon_want;
  int             mon_stall_left;
  int             mon_calm;
  int             mon_roll;

  text_console_writer_top #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .kind_i          (kind_i),
    .char_code_i     (char_code_i),
    .col_arg_i       (col_arg_i),
    .row_arg_i       (row_arg_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .cursor_x_o      (cursor_x_o),
    .cursor_y_o      (cursor_y_o),
    .cursor_offset_o (cursor_offset_o),
    .read_data_o     (read_data_o),
    .scrolled_o      (scrolled_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  // clock
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // cycle budget
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic report_error(input string msg);
    if (err_cnt < MAX_ERR_LINES) $display("ERROR cycle %0d: %s", cycle_cnt, msg);
    err_cnt++;
  endtask

  // apply one request to the shadow console and return its report
  function automatic cursor_report_t console_step(input console_req_t rq);
    cursor_report_t    rep;
    logic [CELL_W-1:0] attr;
    int                k;
    rep  = '0;
    attr = {model_bg, model_fg, 8'h00};
    case (rq.kind)
      KIND_WRITE: begin
        if (rq.code == CODE_BS) begin
          if (cur_col > 0) begin
            cur_col--;
            shadow_screen[cur_row * COLUMNS + cur_col] = attr | {8'h00, CODE_SPACE};
          end
        end else if (rq.code == CODE_CR) begin
          cur_col = 0;
        end else if (rq.code == CODE_LF) begin
          cur_col = 0;
          cur_row++;
        end else if (rq.code >= CODE_FIRST && rq.code <= CODE_LAST) begin
          shadow_screen[cur_row * COLUMNS + cur_col] = attr | {8'h00, rq.code};
          cur_col++;
        end
        if (cur_col >= COLUMNS) begin
          cur_col = 0;
          cur_row++;
        end
        // scroll up one row, bottom row comes in blank
        if (cur_row >= ROWS) begin
          for (k = 0; k < CELLS - COLUMNS; k++) shadow_screen[k] = shadow_screen[k + COLUMNS];
          for (k = CELLS - COLUMNS; k < CELLS; k++) shadow_screen[k] = '0;
          cur_row      = ROWS - 1;
          rep.scrolled = 1'b1;
        end
      end
      KIND_CLEAR: begin
        for (k = 0; k < CELLS; k++) shadow_screen[k] = CLEAR_CELL;
        cur_col = 0;
        cur_row = 0;
      end
      KIND_SET: begin
        cur_col = (rq.col > COLUMNS - 1) ? COLUMNS - 1 : int'(rq.col);
        cur_row = (rq.row > ROWS - 1) ? ROWS - 1 : int'(rq.row);
      end
      KIND_MOVE: begin
        cur_col = (cur_col + int'(rq.col) > COLUMNS - 1) ? COLUMNS - 1 : cur_col + int'(rq.col);
        cur_row = (cur_row + int'(rq.row) > ROWS - 1) ? ROWS - 1 : cur_row + int'(rq.row);
      end
      KIND_READ: begin
        if (rq.col < COLUMNS && rq.row < ROWS)
          rep.rdata = shadow_screen[int'(rq.row) * COLUMNS + int'(rq.col)];
      end
      default: ;
    endcase
    rep.x      = COL_W'(cur_col);
    rep.y      = ROW_W'(cur_row);
    rep.offset = OFFSET_W'(cur_row * COLUMNS + cur_col);
    return rep;
  endfunction

  task automatic push_req(input logic [KIND_W-1:0] kind, input logic [CHAR_W-1:0] code,
                          input logic [ARG_W-1:0] col, input logic [ARG_W-1:0] row);
    console_req_t rq;
    rq.kind = kind;
    rq.code = code;
    rq.col  = col;
    rq.row  = row;
    pending_reqs.push_back(rq);
  endtask

  // random byte in a closed range
  function automatic logic [ARG_W-1:0] rand_byte(input int lo, input int hi);
    return ARG_W'($urandom_range(lo, hi));
  endfunction

  // one random sequence; returns the number of requests queued
  task automatic queue_random_sequence(output int added);
    int               pick;
    int               roll;
    int               len;
    int               k;
    logic [ARG_W-1:0] c;
    logic [ARG_W-1:0] r;
    added = 0;
    pick  = $urandom_range(0, 99);
    if (pick < 55) begin
      // text burst at a fresh cursor position, mostly away from the bottom
      c    = ($urandom_range(0, 9) == 0) ? rand_byte(0, 255) : rand_byte(0, COLUMNS - 1);
      roll = $urandom_range(0, 99);
      if (roll < 80) r = rand_byte(0, ROWS - 5);
      else if (roll < 95) r = rand_byte(ROWS - 3, ROWS - 1);
      else r = rand_byte(0, 255);
      push_req(KIND_SET, rand_byte(0, 255), c, r);
      added++;
      len = $urandom_range(4, 24);
      for (k = 0; k < len; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 80) push_req(KIND_WRITE, rand_byte(int'(CODE_FIRST), int'(CODE_LAST)), 0, 0);
        else if (roll < 86) push_req(KIND_WRITE, CODE_BS, rand_byte(0, 255), 0);
        else if (roll < 90) push_req(KIND_WRITE, CODE_CR, 0, rand_byte(0, 255));
        else if (roll < 93) push_req(KIND_WRITE, CODE_LF, 0, 0);
        else push_req(KIND_WRITE, rand_byte(0, 255), 0, 0);
      end
      added += len;
    end else if (pick < 65) begin
      // cursor move, small deltas mostly
      if ($urandom_range(0, 3) != 0)
        push_req(KIND_MOVE, rand_byte(0, 255), rand_byte(0, 6), rand_byte(0, 6));
      else
        push_req(KIND_MOVE, rand_byte(0, 255), rand_byte(0, 255), rand_byte(0, 255));
      added++;
    end else if (pick < 80) begin
      // cell reads, now and then outside the screen
      len = $urandom_range(1, 4);
      for (k = 0; k < len; k++) begin
        if ($urandom_range(0, 4) != 0)
          push_req(KIND_READ, rand_byte(0, 255), rand_byte(0, COLUMNS - 1),
                   rand_byte(0, ROWS - 1));
        else
          push_req(KIND_READ, rand_byte(0, 255), rand_byte(0, 255), rand_byte(0, 255));
      end
      added += len;
    end else if (pick < 88) begin
      c = rand_byte(0, 255);
      r = rand_byte(0, 255);
      push_req(KIND_SET, 0, c, r);
      push_req(KIND_READ, 0, c, r);
      added += 2;
    end else if (pick < 91) begin
      push_req(KIND_CLEAR, rand_byte(0, 255), rand_byte(0, 255), rand_byte(0, 255));
      added++;
    end else if (pick < 96) begin
      // noise over every field
      push_req(KIND_W'($urandom_range(0, 7)), rand_byte(0, 255), rand_byte(0, 255),
               rand_byte(0, 255));
      added++;
    end else begin
      // broken text with arbitrary bytes
      len = $urandom_range(3, 8);
      for (k = 0; k < len; k++) push_req(KIND_WRITE, rand_byte(0, 255), 0, 0);
      added += len;
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_reqs.size() != 0 || in_valid_i || expected_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // called on a clock edge; returns on the edge that takes the write
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [COLOUR_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    if (idx == CFG_IDX_FG) model_fg = val;
    else if (idx == CFG_IDX_BG) model_bg = val;
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      kind_i      <= '0;
      char_code_i <= '0;
      col_arg_i   <= '0;
      row_arg_i   <= '0;
      drv_gap  = 0;
      drv_calm = 0;
    end else begin
      if (in_valid_i && !in_stall_o) expected_reports.push_back(console_step(drv_cur));
      if (!in_valid_i || !in_stall_o) begin
        if (drv_gap > 0) begin
          drv_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          drv_cur = pending_reqs.pop_front();
          kind_i      <= drv_cur.kind;
          char_code_i <= drv_cur.code;
          col_arg_i   <= drv_cur.col;
          row_arg_i   <= drv_cur.row;
          in_valid_i  <= 1'b1;
          // gap after this request: mostly none or short, a few long
          if (drv_calm > 0) begin
            drv_calm--;
            drv_gap = 0;
          end else begin
            drv_roll = $urandom_range(0, 99);
            if (drv_roll < 2) drv_calm = $urandom_range(30, 150);
            if (drv_roll < 55) drv_gap = 0;
            else if (drv_roll < 92) drv_gap = $urandom_range(1, 3);
            else drv_gap = $urandom_range(8, 40);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // report monitor and output stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      mon_stall_left = 0;
      mon_calm       = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_reports.size() == 0) begin
          report_error("report with no request outstanding");
        end else begin
          mon_want = expected_reports.pop_front();
          if (cursor_x_o !== mon_want.x)
            report_error($sformatf("cursor_x %0d, want %0d", cursor_x_o, mon_want.x));
          if (cursor_y_o !== mon_want.y)
            report_error($sformatf("cursor_y %0d, want %0d", cursor_y_o, mon_want.y));
          if (cursor_offset_o !== mon_want.offset)
            report_error($sformatf("cursor_offset %0d, want %0d", cursor_offset_o,
                                   mon_want.offset));
          if (read_data_o !== mon_want.rdata)
            report_error($sformatf("read_data %h, want %h", read_data_o, mon_want.rdata));
          if (scrolled_o !== mon_want.scrolled)
            report_error($sformatf("scrolled %b, want %b", scrolled_o, mon_want.scrolled));
        end
      end
      // stall pattern: calm stretches, short stalls, a few long ones
      if (mon_calm > 0) begin
        mon_calm--;
        mon_stall_left = 0;
      end else if (mon_stall_left > 0) begin
        mon_stall_left--;
      end else begin
        mon_roll = $urandom_range(0, 999);
        if (mon_roll < 5) mon_calm = $urandom_range(50, 200);
        else if (mon_roll < 150) mon_stall_left = $urandom_range(1, 3);
        else if (mon_roll < 170) mon_stall_left = $urandom_range(10, 40);
      end
      out_stall_i <= (mon_stall_left != 0);
    end
  end

  // stimulus phases
  initial begin
    int                  added;
    int                  total;
    int                  p;
    logic [COLOUR_W-1:0] fg_plan [RANDOM_PHASES];
    logic [COLOUR_W-1:0] bg_plan [RANDOM_PHASES];
    fg_plan = '{4'd15, 4'd0, 4'd7, 4'd0, 4'd15, 4'd0, 4'd0, 4'd2};
    bg_plan = '{4'd15, 4'd0, 4'd9, 4'd15, 4'd0, 4'd0, 4'd0, 4'd0};
    for (p = 0; p < CELLS; p++) shadow_screen[p] = '0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: printable edges, ignored codes, control codes
    push_req(KIND_WRITE, 8'h41, 0, 0);
    push_req(KIND_WRITE, CODE_FIRST, 0, 0);
    push_req(KIND_WRITE, CODE_LAST, 0, 0);
    push_req(KIND_WRITE, CODE_FIRST - 8'd1, 0, 0);
    push_req(KIND_WRITE, CODE_LAST + 8'd1, 0, 0);
    push_req(KIND_WRITE, 8'hFF, 8'hFF, 8'hFF);
    push_req(KIND_WRITE, CODE_BS, 0, 0);
    push_req(KIND_WRITE, CODE_CR, 0, 0);
    push_req(KIND_WRITE, CODE_BS, 0, 0);
    push_req(KIND_WRITE, CODE_LF, 0, 0);
    push_req(KIND_READ, 0, 0, 0);
    push_req(KIND_READ, 0, 2, 0);
    // saturated set, wrap on the last cell, scroll
    push_req(KIND_SET, 0, 8'hFF, 8'hFF);
    push_req(KIND_WRITE, 8'h5A, 0, 0);
    push_req(KIND_READ, 0, ARG_W'(COLUMNS - 1), ARG_W'(ROWS - 2));
    push_req(KIND_READ, 0, 10, ARG_W'(ROWS - 1));
    push_req(KIND_READ, 0, ARG_W'(COLUMNS), 0);
    push_req(KIND_READ, 0, 0, ARG_W'(ROWS));
    push_req(KIND_MOVE, 0, 8'hFF, 8'hFF);
    push_req(KIND_WRITE, CODE_LF, 0, 0);
    push_req(KIND_SPARE_LO, 8'hFF, 8'hFF, 8'hFF);
    push_req(KIND_SPARE_HI, 0, 0, 0);
    push_req(KIND_CLEAR, 0, 0, 0);
    push_req(KIND_READ, 0, 0, 0);
    push_req(KIND_SET, 0, ARG_W'(COLUMNS - 1), 0);
    push_req(KIND_WRITE, 8'h7E, 0, 0);
    wait_idle();

    for (p = 0; p < RANDOM_PHASES; p++) begin
      // reprogram colours while idle
      if (p == 5 || p == 6) begin
        fg_plan[p] = COLOUR_W'($urandom_range(0, 15));
        bg_plan[p] = COLOUR_W'($urandom_range(0, 15));
      end
      if (p == 3) write_reg(CFG_IDX_SPARE, 4'hF);
      write_reg(CFG_IDX_FG, fg_plan[p]);
      write_reg(CFG_IDX_BG, bg_plan[p]);
      cfg_valid_i <= 1'b0;
      total = 0;
      while (total < REQS_PER_PHASE) begin
        queue_random_sequence(added);
        total += added;
      end
      wait_idle();
    end

    if (err_cnt == 0 && expected_reports.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

/* files.f */
hdl/tcw_pkg.sv
hdl/tcw_ram.sv
hdl/tcw_ctrl.sv
hdl/tcw_datapath.sv
hdl/text_console_writer_top.sv
tb/tb.sv
